// ===== hw/rtl/dbdg_pkg.sv =====
// shared types and constants for the dma burst descriptor generator
package dbdg_pkg;

	// chunk sizing limits
	localparam int MAX_LOG_BURST = 4;
	localparam int MAX_BURSTS    = 256;

	// derived widths
	localparam int LG_W   = $clog2(MAX_LOG_BURST + 1);
	localparam int NB_W   = $clog2(MAX_BURSTS + 1);
	localparam int BEAT_W = NB_W + MAX_LOG_BURST;

	// field widths of the item ports
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 32;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;

	// command codes
	localparam logic CMD_START    = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_CHUNK      = 3'd0,
		ST_DONE       = 3'd1,
		ST_BUSY       = 3'd2,
		ST_MISALIGNED = 3'd3,
		ST_STRAY      = 3'd4
	} status_t;

	// fixed bits of the channel program words
	localparam logic [WORD_W-1:0] W0_BASE     = 32'hC007_0000;
	localparam logic [WORD_W-1:0] W0_LOW      = 32'h0000_01BC;
	localparam logic [WORD_W-1:0] W1_BASE     = 32'h00BC_0000;
	localparam logic [WORD_W-1:0] W1_LOW      = 32'h0000_0001;
	localparam logic [15:0]       W3_OPCODE   = 16'h02BC;
	localparam logic [WORD_W-1:0] W4_LOOP     = 32'h0020_0000;
	localparam logic [2:0]        ALIGN_MASK  = 3'h7;

endpackage

// ===== hw/rtl/dma_burst_descriptor_generator.sv =====
// dma burst descriptor generator: splits copy requests into five-word channel programs
//
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  in      | in_valid/in_ready  | command, dest_addr, src_addr, length_beats
//  out     | out_valid/out_ready| status, program_word0..4, last_chunk
//
// every item yields exactly one result item, which passes from the input register
// into the result register. one item per cycle sustained while out_ready holds:
// input register, one decode/pack pass, result register.
// the transfer state (busy, remaining beats, next addresses) updates as an item
// moves from the input register into the result register.
// a stalled result holds the pass; the input register still takes one more item.
// arst_n clears valid flags and transfer state; payload registers are not reset.
module dma_burst_descriptor_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [dbdg_pkg::ADDR_W-1:0]   dest_addr,
	input  logic [dbdg_pkg::ADDR_W-1:0]   src_addr,
	input  logic [dbdg_pkg::LEN_W-1:0]    length_beats,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dbdg_pkg::STATUS_W-1:0] status,
	output logic [dbdg_pkg::WORD_W-1:0]   program_word0,
	output logic [dbdg_pkg::WORD_W-1:0]   program_word1,
	output logic [dbdg_pkg::WORD_W-1:0]   program_word2,
	output logic [dbdg_pkg::WORD_W-1:0]   program_word3,
	output logic [dbdg_pkg::WORD_W-1:0]   program_word4,
	output logic                          last_chunk
);
	import dbdg_pkg::*;

	// input stage
	logic               valid_s1;
	logic               cmd_s1;
	logic [ADDR_W-1:0]  dest_s1;
	logic [ADDR_W-1:0]  src_s1;
	logic [LEN_W-1:0]   len_s1;

	// transfer state
	logic               busy_q;
	logic [LEN_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  next_dest_q;
	logic [ADDR_W-1:0]  next_src_q;

	// result register
	logic               out_valid_q;
	status_t            status_q;
	logic [WORD_W-1:0]  word0_q, word1_q, word2_q, word3_q, word4_q;
	logic               last_q;

	// pass logic
	logic               advance;
	logic               is_start;
	logic               misaligned;
	logic               emit;
	logic               go_idle;
	status_t            res_status;
	logic [LEN_W-1:0]   rem_sel;
	logic [ADDR_W-1:0]  dest_sel, src_sel;
	logic [LG_W-1:0]    lg;
	logic [LEN_W-1:0]   shifted;
	logic [NB_W-1:0]    nbursts;
	logic [BEAT_W-1:0]  beats;
	logic [LEN_W-1:0]   rem_next;
	logic [ADDR_W-1:0]  addr_step;
	logic [3:0]         burst_m1;
	logic [7:0]         nb_m1;
	logic [WORD_W-1:0]  w0, w1, w2, w3, w4;
	logic               res_last;

	// handshake: pass moves when the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			dest_s1 <= dest_addr;
			src_s1  <= src_addr;
			len_s1  <= length_beats;
		end
	end

	// command decode and status pick
	always_comb begin
		is_start   = (cmd_s1 == CMD_START);
		misaligned = ((dest_s1[2:0] & ALIGN_MASK) != 3'd0) ||
		             ((src_s1[2:0] & ALIGN_MASK) != 3'd0);
		emit       = 1'b0;
		go_idle    = 1'b0;
		res_status = ST_CHUNK;
		if (is_start) begin
			if (busy_q) begin
				res_status = ST_BUSY;
			end else if (misaligned) begin
				res_status = ST_MISALIGNED;
			end else if (len_s1 == '0) begin
				res_status = ST_DONE;
			end else begin
				emit = 1'b1;
			end
		end else begin
			if (!busy_q) begin
				res_status = ST_STRAY;
			end else if (rem_q == '0) begin
				res_status = ST_DONE;
				go_idle    = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end
	end

	// chunk sizing: burst length pick, burst count clamp, address step
	always_comb begin
		rem_sel  = is_start ? len_s1  : rem_q;
		dest_sel = is_start ? dest_s1 : next_dest_q;
		src_sel  = is_start ? src_s1  : next_src_q;
		lg = '0;
		for (int i = 1; i <= MAX_LOG_BURST; i++) begin
			if (rem_sel >= (LEN_W'(1) << i)) begin
				lg = LG_W'(i);
			end
		end
		shifted = rem_sel >> lg;
		if (shifted > LEN_W'(MAX_BURSTS)) begin
			nbursts = NB_W'(MAX_BURSTS);
		end else begin
			nbursts = NB_W'(shifted);
		end
		beats     = BEAT_W'(nbursts) << lg;
		rem_next  = rem_sel - LEN_W'(beats);
		addr_step = ADDR_W'({beats, 3'b000});
		burst_m1  = 4'((LEN_W'(1) << lg) - LEN_W'(1));
		nb_m1     = 8'(nbursts - NB_W'(1));
	end

	// program word packing, zero for non-chunk results
	always_comb begin
		w0       = '0;
		w1       = '0;
		w2       = '0;
		w3       = '0;
		w4       = '0;
		res_last = 1'b0;
		if (emit) begin
			w0       = W0_BASE | (WORD_W'(burst_m1) << 20) | W0_LOW;
			w1       = W1_BASE | (WORD_W'(burst_m1) << 2) | W1_LOW;
			w2       = src_sel;
			w3       = {dest_sel[15:0], W3_OPCODE};
			w4       = (WORD_W'(nb_m1) << 24) | W4_LOOP | WORD_W'(dest_sel[31:16]);
			res_last = (rem_next == '0);
		end
	end

	// transfer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			next_dest_q <= '0;
			next_src_q  <= '0;
		end else if (valid_s1 && advance) begin
			if (emit) begin
				busy_q      <= 1'b1;
				rem_q       <= rem_next;
				next_dest_q <= dest_sel + addr_step;
				next_src_q  <= src_sel + addr_step;
			end else if (go_idle) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			status_q <= res_status;
			word0_q  <= w0;
			word1_q  <= w1;
			word2_q  <= w2;
			word3_q  <= w3;
			word4_q  <= w4;
			last_q   <= res_last;
		end
	end

	// outputs
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign program_word0 = word0_q;
	assign program_word1 = word1_q;
	assign program_word2 = word2_q;
	assign program_word3 = word3_q;
	assign program_word4 = word4_q;
	assign last_chunk    = last_q;

	// idle block holds no leftover beats
	a_idle_no_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (rem_q == '0))
		else $error("idle with remaining beats");

	// an emitted chunk leaves the block busy
	a_chunk_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && emit) |=> busy_q)
		else $error("chunk emitted but block not busy");

	// non-chunk results carry an empty program
	a_error_words_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_CHUNK) |->
		(word0_q == '0 && word2_q == '0 && word4_q == '0 && !last_q))
		else $error("non-chunk result with program words");

	// the final chunk drains the remaining beat count
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && emit && res_last) |=> (rem_q == '0))
		else $error("last chunk left beats behind");

endmodule

// ===== dv/dma_burst_descriptor_generator_checker.sv =====
// checker for the dma burst descriptor generator: predicts each result item and compares
module dma_burst_descriptor_generator_checker
	import dbdg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                command,
	input  logic [ADDR_W-1:0]   dest_addr,
	input  logic [ADDR_W-1:0]   src_addr,
	input  logic [LEN_W-1:0]    length_beats,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [STATUS_W-1:0] status,
	input  logic [WORD_W-1:0]   program_word0,
	input  logic [WORD_W-1:0]   program_word1,
	input  logic [WORD_W-1:0]   program_word2,
	input  logic [WORD_W-1:0]   program_word3,
	input  logic [WORD_W-1:0]   program_word4,
	input  logic                last_chunk,
	output int                  mismatches,
	output int                  pending,
	output int                  chunks_seen,
	output int                  dones_seen,
	output int                  rejects_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t                 status;
		logic [4:0][WORD_W-1:0]  word;
		logic                    last;
	} program_t;

	// predicted transfer state
	logic              xfer_busy;
	logic [LEN_W-1:0]  beats_left;
	logic [ADDR_W-1:0] dest_next;
	logic [ADDR_W-1:0] src_next;

	program_t expected_programs[$];
	int n_mismatch, n_chunk, n_done, n_reject;

	// encode one chunk from the current position and advance past it
	function automatic program_t next_chunk();
		program_t         p;
		int unsigned      lg;
		logic [LEN_W-1:0] burst, nbursts, beats;
		logic [3:0]       bm1;
		logic [7:0]       nbm1;
		lg = MAX_LOG_BURST;
		while (lg > 0 && (32'd1 << lg) > beats_left)
			lg--;
		burst = 32'd1 << lg;
		nbursts = beats_left >> lg;
		if (nbursts > MAX_BURSTS)
			nbursts = MAX_BURSTS;
		beats = nbursts << lg;
		bm1 = 4'(burst - 1);
		nbm1 = 8'(nbursts - 1);
		p.status = ST_CHUNK;
		p.word[0] = W0_BASE | {8'h0, bm1, 20'h0} | W0_LOW;
		p.word[1] = W1_BASE | {26'h0, bm1, 2'b00} | W1_LOW;
		p.word[2] = src_next;
		p.word[3] = {dest_next[15:0], W3_OPCODE};
		p.word[4] = {nbm1, 24'h0} | W4_LOOP | {16'h0, dest_next[31:16]};
		beats_left = beats_left - beats;
		dest_next = dest_next + (beats << 3);
		src_next = src_next + (beats << 3);
		p.last = (beats_left == 0);
		return p;
	endfunction

	// expected result of one accepted item, updating the predicted state
	function automatic program_t predict_program(input logic cmd,
			input logic [ADDR_W-1:0] d, input logic [ADDR_W-1:0] s,
			input logic [LEN_W-1:0] len);
		program_t p;
		p = '0;
		if (cmd == CMD_START) begin
			if (xfer_busy)
				p.status = ST_BUSY;
			else if ((d[2:0] & ALIGN_MASK) != 0 || (s[2:0] & ALIGN_MASK) != 0)
				p.status = ST_MISALIGNED;
			else if (len == 0)
				p.status = ST_DONE;
			else begin
				dest_next = d;
				src_next = s;
				beats_left = len;
				xfer_busy = 1'b1;
				p = next_chunk();
			end
		end else if (!xfer_busy) begin
			p.status = ST_STRAY;
		end else if (beats_left == 0) begin
			xfer_busy = 1'b0;
			p.status = ST_DONE;
		end else begin
			p = next_chunk();
		end
		return p;
	endfunction

	// compare result items in order, then predict newly accepted items
	always @(posedge clk or negedge arst_n) begin
		program_t exp_p, act_p;
		if (!arst_n) begin
			xfer_busy = 1'b0;
			beats_left = '0;
			dest_next = '0;
			src_next = '0;
			expected_programs.delete();
			n_mismatch = 0;
			n_chunk = 0;
			n_done = 0;
			n_reject = 0;
		end else begin
			if (out_valid && out_ready) begin
				act_p.status = status_t'(status);
				act_p.word[0] = program_word0;
				act_p.word[1] = program_word1;
				act_p.word[2] = program_word2;
				act_p.word[3] = program_word3;
				act_p.word[4] = program_word4;
				act_p.last = last_chunk;
				if (expected_programs.size() == 0) begin
					n_mismatch++;
					$display("%0t unexpected result item: expected none, actual status %0d",
						$time, status);
				end else begin
					exp_p = expected_programs.pop_front();
					if (status !== exp_p.status) begin
						n_mismatch++;
						$display("%0t status mismatch: expected %0d actual %0d",
							$time, exp_p.status, status);
					end
					for (int i = 0; i < 5; i++) begin
						if (act_p.word[i] !== exp_p.word[i]) begin
							n_mismatch++;
							$display("%0t program_word%0d mismatch: expected %h actual %h",
								$time, i, exp_p.word[i], act_p.word[i]);
						end
					end
					if (last_chunk !== exp_p.last) begin
						n_mismatch++;
						$display("%0t last_chunk mismatch: expected %b actual %b",
							$time, exp_p.last, last_chunk);
					end
					case (exp_p.status)
						ST_CHUNK: n_chunk++;
						ST_DONE:  n_done++;
						default:  n_reject++;
					endcase
				end
			end
			if (in_valid && in_ready)
				expected_programs.push_back(predict_program(command, dest_addr,
					src_addr, length_beats));
		end
		mismatches <= n_mismatch;
		pending <= expected_programs.size();
		chunks_seen <= n_chunk;
		dones_seen <= n_done;
		rejects_seen <= n_reject;
	end

endmodule

// ===== dv/dma_burst_descriptor_generator_tb.sv =====
// testbench top for the dma burst descriptor generator: stimulus, clocking and verdict
module dma_burst_descriptor_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dbdg_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_ITEMS = 233;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                command = CMD_START;
	logic [ADDR_W-1:0]   dest_addr = '0;
	logic [ADDR_W-1:0]   src_addr = '0;
	logic [LEN_W-1:0]    length_beats = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   program_word0, program_word1, program_word2;
	logic [WORD_W-1:0]   program_word3, program_word4;
	logic                last_chunk;

	int mismatches, pending, chunks_seen, dones_seen, rejects_seen;
	int items_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	// receiver hold-off request, toggled by the stimulus
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	dma_burst_descriptor_generator dut (.*);

	dma_burst_descriptor_generator_checker checker_i (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver: random stalls plus a long hold-off whenever the stimulus toggles the request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			hold_seen = hold_toggle;
		end else if (hold_seen != hold_toggle) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// offer one item after a random gap and wait for its acceptance
	task automatic send_item(input logic cmd, input logic [ADDR_W-1:0] d,
			input logic [ADDR_W-1:0] s, input logic [LEN_W-1:0] len);
		logic ready_seen;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		dest_addr <= d;
		src_addr <= s;
		length_beats <= len;
		do begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
		end while (!ready_seen);
		items_sent++;
	endtask

	// completion with don't-care payload
	task automatic send_completion();
		send_item(CMD_COMPLETE, $urandom, $urandom, $urandom);
	endtask

	// number of chunk programs a transfer of this length splits into
	function automatic int count_chunks(input logic [LEN_W-1:0] len);
		int               n;
		int unsigned      lg;
		logic [LEN_W-1:0] left, nb;
		n = 0;
		left = len;
		while (left != 0) begin
			lg = MAX_LOG_BURST;
			while (lg > 0 && (32'd1 << lg) > left)
				lg--;
			nb = left >> lg;
			if (nb > MAX_BURSTS)
				nb = MAX_BURSTS;
			left = left - (nb << lg);
			n++;
		end
		return n;
	endfunction

	// start a transfer and complete every chunk; noisy may add busy starts and a stray
	task automatic run_transfer(input logic [ADDR_W-1:0] d, input logic [ADDR_W-1:0] s,
			input logic [LEN_W-1:0] len, input bit noisy);
		int n;
		n = count_chunks(len);
		send_item(CMD_START, d, s, len);
		for (int i = 0; i < n; i++) begin
			if (noisy && $urandom_range(99) < 8)
				send_item(CMD_START, $urandom, $urandom, $urandom);
			send_completion();
		end
		if (noisy && $urandom_range(99) < 10)
			send_completion();
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return $urandom_range(40, 1);
		if (r < 85)
			return $urandom_range(300, 1);
		if (r < 95)
			return $urandom_range(9000, 4000);
		return 32'd1 << $urandom_range(12, 0);
	endfunction

	// mostly well-formed transfers, the rest rejected, stray or zero-length items
	task automatic run_random(input int target);
		logic [ADDR_W-1:0] d, s;
		while (items_sent < target) begin
			if ($urandom_range(99) < 78) begin
				run_transfer($urandom & 32'hFFFF_FFF8, $urandom & 32'hFFFF_FFF8,
					pick_length(), 1'b1);
			end else begin
				case ($urandom_range(2))
					0: send_completion();
					1: begin
						d = $urandom;
						s = $urandom;
						if (d[2:0] == 3'b000 && s[2:0] == 3'b000)
							d[$urandom_range(2)] = 1'b1;
						send_item(CMD_START, d, s, $urandom);
					end
					default: send_item(CMD_START, $urandom & 32'hFFFF_FFF8,
						$urandom & 32'hFFFF_FFF8, '0);
				endcase
			end
		end
	endtask

	// stop offering and wait for every outstanding result item
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejects, zero length, wrap, max bursts, shrinking bursts
		send_completion();
		send_item(CMD_COMPLETE, '1, '1, '1);
		send_item(CMD_START, 32'h0000_1000, 32'h0000_2000, '0);
		send_item(CMD_START, 32'h0000_1004, 32'h0000_2000, 32'd8);
		send_item(CMD_START, 32'h0000_1000, 32'h0000_2001, 32'd8);
		send_item(CMD_START, 32'hFFFF_FFF0, 32'h0000_0000, 32'd17);
		send_item(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_completion();
		send_completion();
		run_transfer(32'h0000_0000, 32'hFFFF_FFF8, 32'h0000_1001, 1'b0);
		run_transfer(32'h8000_0008, 32'h7FFF_FFF8, 32'd15, 1'b0);
		run_transfer(32'h0000_0040, 32'h0000_0080, 32'd1, 1'b0);
		wait_drained();

		// phase 0: no idling, with a long receiver hold-off while items keep coming
		hold_toggle <= ~hold_toggle;
		run_random(items_sent + 30);
		wait_drained();
		run_random(items_sent + PHASE_ITEMS - 30);
		wait_drained();

		// phase 1: sender idles often
		idle_pct = 74;
		stall_pct = 0;
		run_random(items_sent + PHASE_ITEMS);
		wait_drained();

		// phase 2: receiver stalls often
		idle_pct = 0;
		stall_pct = 74;
		run_random(items_sent + PHASE_ITEMS);
		wait_drained();

		// phase 3: both sides idle
		idle_pct = 29;
		stall_pct = 29;
		run_random(items_sent + PHASE_ITEMS);
		wait_drained();
		repeat (10) @(posedge clk);

		$display("summary: %0d items sent; %0d chunk programs, %0d done, %0d rejected or stray",
			items_sent, chunks_seen, dones_seen, rejects_seen);
		$display("covered: no idling, sender 74%%, receiver 74%%, both 29%%, one long hold-off");
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d result items outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
